// ----- hw/rtl/lrbl_pkg.sv -----
// Shared constants and controller-to-datapath command type for the LCG random generator.
`timescale 1ns / 1ps
`default_nettype none

package lrbl_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned WORD_W  = 31;
    localparam int unsigned LIMIT_W = 32;

    localparam logic [SEED_W-1:0] LCG_MUL     = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD     = 32'd12345;
    localparam logic [SEED_W-1:0] SEED_OFFSET = 32'd51284;

    // Three generator steps, then one remainder bit per cycle over the word.
    localparam int unsigned LCG_STEPS = 3;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;        // capture request, reload seed if it is zero
        logic step;        // advance the seed once and fold bits into the word
        logic step_first;  // first advance: word starts from eleven bits
        logic div_step;    // one restoring remainder iteration
        logic out_load;    // move the finished result into the output register
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrbl_if.sv -----
// Request and response channel interfaces for the LCG random generator.
`timescale 1ns / 1ps
`default_nettype none

interface lrbl_req_if;
    logic                                valid;
    logic                                ready;
    logic [lrbl_pkg::LIMIT_W-1:0]        limit;
    logic [lrbl_pkg::SEED_W-1:0]         tick_now;

    modport source (output valid, output limit, output tick_now, input ready);
    modport sink   (input valid, input limit, input tick_now, output ready);
endinterface

interface lrbl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lrbl_pkg::WORD_W-1:0]         value;
    logic                                limit_zero;

    modport source (output valid, output value, output limit_zero, input ready);
    modport sink   (input valid, input value, input limit_zero, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lcg_random_below_limit.sv -----
// Top level of the LCG random generator returning a value below a requested limit.
//
//  channel | dir | payload                      | beat
//  req     | in  | limit[31:0], tick_now[31:0]  | valid & ready
//  rsp     | out | value[30:0], limit_zero      | valid & ready
//
// From acceptance, a request makes three seed advances through the single 32x32
// multiplier, one remainder step per word bit and one output load before its result is valid.
// A new request is accepted only in the idle state, once the previous one is done.
// The seed resets to zero, so the first request reloads it from tick_now.
// A new request is taken while the last result still waits; a request only
// stalls in its final cycle if that older result has not yet been read.
`timescale 1ns / 1ps
`default_nettype none

module lcg_random_below_limit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lrbl_req_if.sink   req,
    lrbl_rsp_if.source rsp
);

    lrbl_pkg::cmd_t cmd;

    lrbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    lrbl_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .limit      (req.limit),
        .tick_now   (req.tick_now),
        .value      (rsp.value),
        .limit_zero (rsp.limit_zero)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lrbl_ctrl.sv -----
// Sequencing state machine for the LCG random generator.
`timescale 1ns / 1ps
`default_nettype none

module lrbl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output lrbl_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [lrbl_pkg::CNT_W-1:0] STEP_LAST =
        lrbl_pkg::CNT_W'(lrbl_pkg::LCG_STEPS - 1);
    localparam logic [lrbl_pkg::CNT_W-1:0] DIV_LAST =
        lrbl_pkg::CNT_W'(lrbl_pkg::DIV_STEPS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [lrbl_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step       = 1'b1;
                cmd.step_first = (cnt_reg == '0);
                if (cnt_reg == STEP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // Wait here only while the previous result is still unread.
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lrbl_dpath.sv -----
// Seed register, LCG step unit, restoring remainder unit and output register.
`timescale 1ns / 1ps
`default_nettype none

module lrbl_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lrbl_pkg::cmd_t                cmd,
    input  wire logic [lrbl_pkg::LIMIT_W-1:0]  limit,
    input  wire logic [lrbl_pkg::SEED_W-1:0]   tick_now,
    output logic      [lrbl_pkg::WORD_W-1:0]   value,
    output logic                               limit_zero
);

    logic [lrbl_pkg::SEED_W-1:0]   seed_reg;
    logic [lrbl_pkg::LIMIT_W-1:0]  limit_reg;
    logic [lrbl_pkg::WORD_W-1:0]   word_reg;
    logic [lrbl_pkg::LIMIT_W-1:0]  rem_reg;
    logic [lrbl_pkg::WORD_W-1:0]   value_reg;
    logic                          limit_zero_reg;

    logic [lrbl_pkg::SEED_W-1:0]   lcg_next;
    logic [lrbl_pkg::LIMIT_W:0]    trial;
    logic [lrbl_pkg::LIMIT_W:0]    diff;
    logic [lrbl_pkg::LIMIT_W-1:0]  rem_next;

    // Low 32 bits of the product are all the rule needs.
    assign lcg_next = seed_reg * lrbl_pkg::LCG_MUL + lrbl_pkg::LCG_ADD;

    // For a nonzero limit the partial remainder stays below it, so the trial stays below twice it.
    assign trial    = {rem_reg, word_reg[lrbl_pkg::WORD_W-1]};
    assign diff     = trial - {1'b0, limit_reg};
    assign rem_next = diff[lrbl_pkg::LIMIT_W] ? trial[lrbl_pkg::LIMIT_W-1:0]
                                              : diff[lrbl_pkg::LIMIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (seed_reg == '0)
            begin
                seed_reg <= tick_now + lrbl_pkg::SEED_OFFSET;
            end
        end
        else if (cmd.step)
        begin
            seed_reg <= lcg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            limit_reg <= limit;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end

        if (cmd.step)
        begin
            if (cmd.step_first)
            begin
                word_reg <= {20'd0, lcg_next[26:16]};
            end
            else
            begin
                word_reg <= {word_reg[lrbl_pkg::WORD_W-11:0], lcg_next[25:16]};
            end
        end
        else if (cmd.div_step)
        begin
            word_reg <= {word_reg[lrbl_pkg::WORD_W-2:0], 1'b0};
        end

        if (cmd.out_load)
        begin
            limit_zero_reg <= (limit_reg == '0);
            value_reg      <= (limit_reg == '0) ? '0 : rem_reg[lrbl_pkg::WORD_W-1:0];
        end
    end

    assign value      = value_reg;
    assign limit_zero = limit_zero_reg;

endmodule

`default_nettype wire
